// ===== hw/rtl/dfs_route_finder_core_macros.svh =====
// ----------------------------------------------------------------------------
// dfs_route_finder_core assertion macros
// Shared assertion forms for the route finder RTL.
// ----------------------------------------------------------------------------
`ifndef DFS_ROUTE_FINDER_CORE_MACROS_SVH
`define DFS_ROUTE_FINDER_CORE_MACROS_SVH

// Implication checked on every edge outside reset.
`define DFS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Invariant checked on every edge outside reset.
`define DFS_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

`endif

// ===== hw/rtl/dfs_pkg.sv =====
// ----------------------------------------------------------------------------
// dfs_pkg
// Types, codes and defaults shared by the route finder modules.
// ----------------------------------------------------------------------------
package dfs_pkg;

  localparam int NUM_CITIES_DEF  = 16;
  localparam int MAX_FLIGHTS_DEF = 64;

  localparam int CITY_W   = 4;
  localparam int NUM_W    = 16;
  localparam int PRICE_W  = 16;
  localparam int COST_W   = 20;
  localparam int STATUS_W = 3;
  localparam int CMD_W    = 2;

  localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ROUTE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  localparam logic [STATUS_W-1:0] ST_STORED   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_LEG      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NO_ROUTE = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_SAME     = 3'd4;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [CITY_W-1:0]  origin_city;
    logic [CITY_W-1:0]  dest_city;
    logic [NUM_W-1:0]   flight_number;
    logic [PRICE_W-1:0] price;
  } in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [NUM_W-1:0]    leg_flight_number;
    logic [CITY_W-1:0]   leg_from;
    logic [CITY_W-1:0]   leg_to;
    logic [PRICE_W-1:0]  leg_price;
    logic [COST_W-1:0]   total_cost;
    logic                last;
  } out_t;

  typedef struct packed {
    logic [CITY_W-1:0]  origin;
    logic [CITY_W-1:0]  dest;
    logic [NUM_W-1:0]   number;
    logic [PRICE_W-1:0] price;
  } flt_t;

  localparam int FLT_W = $bits(flt_t);

  typedef struct packed {
    logic                tab_wr;
    logic                cnt_clr;
    logic                q_init;
    logic                push;
    logic                pop;
    logic                scan_start;
    logic                scan_run;
    logic                emit_start;
    logic                leg_rd;
    logic                leg_next;
    logic                out_ld;
    logic [STATUS_W-1:0] out_status;
  } dfs_cmd_t;

  typedef struct packed {
    logic same_city;
    logic org_ok;
    logic tab_full;
    logic sp_zero;
    logic top_is_dst;
    logic stack_full;
    logic hit;
    logic miss;
    logic slot_free;
    logic last_leg;
  } dfs_sts_t;

endpackage

// ===== hw/rtl/dfs_ram.sv =====
// ----------------------------------------------------------------------------
// dfs_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module dfs_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             we,
  input  logic             re,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/dfs_dp.sv =====
// ----------------------------------------------------------------------------
// dfs_dp
// Route search datapath: flight table, city/leg stacks, visited marks, output.
// ----------------------------------------------------------------------------
`include "dfs_route_finder_core_macros.svh"

module dfs_dp #(
  parameter int NUM_CITIES  = dfs_pkg::NUM_CITIES_DEF,
  parameter int MAX_FLIGHTS = dfs_pkg::MAX_FLIGHTS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  dfs_pkg::in_t     in_data,
  input  dfs_pkg::dfs_cmd_t cmd,
  output dfs_pkg::dfs_sts_t sts,
  output logic             out_valid,
  input  logic             out_ready,
  output dfs_pkg::out_t    out_data
);

  localparam int CIW  = $clog2(NUM_CITIES);
  localparam int SPW  = $clog2(NUM_CITIES + 1);
  localparam int LIW  = (NUM_CITIES > 2) ? $clog2(NUM_CITIES - 1) : 1;
  localparam int AW   = (MAX_FLIGHTS > 1) ? $clog2(MAX_FLIGHTS) : 1;
  localparam int CNTW = $clog2(MAX_FLIGHTS + 1);
  localparam int CW   = dfs_pkg::CITY_W;

  logic [CNTW-1:0]    cnt_r;
  logic [CW-1:0]      dst_r;
  logic [NUM_CITIES-1:0] visited_r;
  logic [CW-1:0]      city_stk_r [NUM_CITIES];
  logic [AW-1:0]      leg_stk_r [NUM_CITIES-1];
  logic [SPW-1:0]     sp_r;
  logic [CNTW-1:0]    scan_r;
  logic               chk_vld_r;
  logic [AW-1:0]      chk_idx_r;
  logic [SPW-1:0]     k_r;
  logic [dfs_pkg::COST_W-1:0] total_r;
  logic               out_valid_r;
  dfs_pkg::out_t      out_r;

  dfs_pkg::flt_t      rd;
  dfs_pkg::flt_t      wr;
  logic [AW-1:0]      ram_addr;
  logic               ram_re;
  logic               issue;
  logic [SPW-1:0]     sp_m1;
  logic [CW-1:0]      top;
  logic               dest_ok;
  logic [dfs_pkg::COST_W:0] sum;
  logic [dfs_pkg::COST_W-1:0] total_nxt;
  dfs_pkg::out_t      out_nxt;

  assign wr.origin = in_data.origin_city;
  assign wr.dest   = in_data.dest_city;
  assign wr.number = in_data.flight_number;
  assign wr.price  = in_data.price;

  assign issue  = scan_r < cnt_r;
  assign sp_m1  = sp_r - SPW'(1);
  assign top    = city_stk_r[sp_m1[CIW-1:0]];
  assign dest_ok = 32'(rd.dest) < NUM_CITIES;

  always_comb begin
    if (cmd.tab_wr) begin
      ram_addr = cnt_r[AW-1:0];
    end else if (cmd.leg_rd) begin
      ram_addr = leg_stk_r[k_r[LIW-1:0]];
    end else begin
      ram_addr = scan_r[AW-1:0];
    end
  end

  assign ram_re = cmd.leg_rd | (cmd.scan_run & issue);

  dfs_ram #(
    .WIDTH(dfs_pkg::FLT_W),
    .DEPTH(MAX_FLIGHTS),
    .AW   (AW)
  ) u_tab (
    .clk  (clk),
    .we   (cmd.tab_wr),
    .re   (ram_re),
    .addr (ram_addr),
    .wdata(wr),
    .rdata(rd)
  );

  assign sum       = {1'b0, total_r} + (dfs_pkg::COST_W + 1)'(rd.price);
  assign total_nxt = sum[dfs_pkg::COST_W] ? '1 : sum[dfs_pkg::COST_W-1:0];

  assign sts.same_city  = in_data.origin_city == in_data.dest_city;
  assign sts.org_ok     = 32'(in_data.origin_city) < NUM_CITIES;
  assign sts.tab_full   = cnt_r == CNTW'(MAX_FLIGHTS);
  assign sts.sp_zero    = sp_r == '0;
  assign sts.top_is_dst = top == dst_r;
  assign sts.stack_full = sp_r == SPW'(NUM_CITIES);
  assign sts.hit        = chk_vld_r && (rd.origin == top) && dest_ok
                          && !visited_r[CIW'(rd.dest)];
  assign sts.miss       = !chk_vld_r && !issue;
  assign sts.slot_free  = !out_valid_r || out_ready;
  assign sts.last_leg   = (k_r + SPW'(2)) == sp_r;

  always_comb begin
    out_nxt        = '0;
    out_nxt.status = cmd.out_status;
    out_nxt.last   = 1'b1;
    if (cmd.out_status == dfs_pkg::ST_LEG) begin
      out_nxt.leg_flight_number = rd.number;
      out_nxt.leg_from          = rd.origin;
      out_nxt.leg_to            = rd.dest;
      out_nxt.leg_price         = rd.price;
      out_nxt.total_cost        = total_nxt;
      out_nxt.last              = sts.last_leg;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      sp_r        <= '0;
      visited_r   <= '0;
      chk_vld_r   <= 1'b0;
      scan_r      <= '0;
      k_r         <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.cnt_clr) begin
        cnt_r <= '0;
      end else if (cmd.tab_wr) begin
        cnt_r <= cnt_r + CNTW'(1);
      end
      if (cmd.q_init) begin
        visited_r <= NUM_CITIES'(1) << in_data.origin_city;
        sp_r <= SPW'(1);
      end else if (cmd.push) begin
        visited_r[CIW'(rd.dest)] <= 1'b1;
        sp_r <= sp_r + SPW'(1);
      end else if (cmd.pop) begin
        sp_r <= sp_m1;
      end
      if (cmd.scan_start) begin
        scan_r    <= '0;
        chk_vld_r <= 1'b0;
      end else if (cmd.scan_run) begin
        if (issue) begin
          scan_r <= scan_r + CNTW'(1);
        end
        chk_vld_r <= issue;
      end
      if (cmd.emit_start) begin
        k_r     <= '0;
        total_r <= '0;
      end else if (cmd.leg_next) begin
        k_r     <= k_r + SPW'(1);
        total_r <= total_nxt;
      end
      if (cmd.out_ld) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.q_init) begin
      dst_r         <= in_data.dest_city;
      city_stk_r[0] <= in_data.origin_city;
    end
    if (cmd.push) begin
      city_stk_r[sp_r[CIW-1:0]] <= rd.dest;
      leg_stk_r[sp_m1[LIW-1:0]] <= chk_idx_r;
    end
    if (cmd.scan_run) begin
      chk_idx_r <= scan_r[AW-1:0];
    end
    if (cmd.out_ld) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `DFS_ASSERT_IMPL(a_ld_slot, cmd.out_ld, !out_valid_r || out_ready, "result overwrites beat")
  `DFS_ASSERT_IMPL(a_push_room, cmd.push, sp_r < SPW'(NUM_CITIES), "push on full stack")
  `DFS_ASSERT_ALWAYS(a_cnt_max, cnt_r <= CNTW'(MAX_FLIGHTS), "flight count overflow")
  `DFS_ASSERT_IMPL(a_scan_rd, cmd.scan_run && ram_re, scan_r < cnt_r, "scan past table end")

endmodule

// ===== hw/rtl/dfs_ctrl.sv =====
// ----------------------------------------------------------------------------
// dfs_ctrl
// Sequencer for add, clear, depth-first search and leg output.
// ----------------------------------------------------------------------------
module dfs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [dfs_pkg::CMD_W-1:0] in_cmd,
  input  dfs_pkg::dfs_sts_t sts,
  output dfs_pkg::dfs_cmd_t cmd
);

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_CHECK   = 6'b000010,
    S_SCAN    = 6'b000100,
    S_NOROUTE = 6'b001000,
    S_EMIT_RD = 6'b010000,
    S_EMIT_LD = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   acc;

  assign in_ready = (state_r == S_IDLE) && sts.slot_free;
  assign acc      = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (acc) begin
          case (in_cmd)
            dfs_pkg::CMD_ADD: begin
              cmd.out_ld = 1'b1;
              if (sts.tab_full) begin
                cmd.out_status = dfs_pkg::ST_FULL;
              end else begin
                cmd.tab_wr     = 1'b1;
                cmd.out_status = dfs_pkg::ST_STORED;
              end
            end
            dfs_pkg::CMD_ROUTE: begin
              if (sts.same_city) begin
                cmd.out_ld     = 1'b1;
                cmd.out_status = dfs_pkg::ST_SAME;
              end else if (!sts.org_ok) begin
                cmd.out_ld     = 1'b1;
                cmd.out_status = dfs_pkg::ST_NO_ROUTE;
              end else begin
                cmd.q_init = 1'b1;
                state_nxt  = S_CHECK;
              end
            end
            dfs_pkg::CMD_CLEAR: begin
              cmd.cnt_clr = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      S_CHECK: begin
        if (sts.sp_zero) begin
          state_nxt = S_NOROUTE;
        end else if (sts.top_is_dst) begin
          cmd.emit_start = 1'b1;
          state_nxt      = S_EMIT_RD;
        end else if (sts.stack_full) begin
          cmd.pop = 1'b1;
        end else begin
          cmd.scan_start = 1'b1;
          state_nxt      = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_run = 1'b1;
        if (sts.hit) begin
          cmd.push  = 1'b1;
          state_nxt = S_CHECK;
        end else if (sts.miss) begin
          cmd.pop   = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_NOROUTE: begin
        if (sts.slot_free) begin
          cmd.out_ld     = 1'b1;
          cmd.out_status = dfs_pkg::ST_NO_ROUTE;
          state_nxt      = S_IDLE;
        end
      end
      S_EMIT_RD: begin
        cmd.leg_rd = 1'b1;
        state_nxt  = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        if (sts.slot_free) begin
          cmd.out_ld     = 1'b1;
          cmd.out_status = dfs_pkg::ST_LEG;
          cmd.leg_next   = 1'b1;
          state_nxt      = sts.last_leg ? S_IDLE : S_EMIT_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hw/rtl/dfs_route_finder_core.sv =====
// ----------------------------------------------------------------------------
// dfs_route_finder_core
// Flight table with a stack-based depth-first route search.
// ----------------------------------------------------------------------------
// Add, clear: taken in the idle state; the add result beat is registered the next cycle.
// Route query: each search step scans the flight table from entry 0, one
//   entry per cycle through the table RAM port.
// Each leg is then emitted in two steps: RAM read, then load of the output register.
// Reset (synchronous, rst_n low) empties the table and idles the sequencer.
module dfs_route_finder_core #(
  parameter int NUM_CITIES  = dfs_pkg::NUM_CITIES_DEF,
  parameter int MAX_FLIGHTS = dfs_pkg::MAX_FLIGHTS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  dfs_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output dfs_pkg::out_t out_data
);

  dfs_pkg::dfs_cmd_t cmd;
  dfs_pkg::dfs_sts_t sts;

  dfs_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_cmd  (in_data.cmd),
    .sts     (sts),
    .cmd     (cmd)
  );

  dfs_dp #(
    .NUM_CITIES (NUM_CITIES),
    .MAX_FLIGHTS(MAX_FLIGHTS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule
